// ===== rtl/appc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// appc_pkg: shared types and constants
// Thresholds, limits, reset values and register indexes of the arm controller.
// ----------------------------------------------------------------------------
package appc_pkg;

  localparam int APPC_POSITION_BITS = 12;
  localparam int APPC_SUM_BITS      = 24;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P      = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I      = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D      = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOOT_LEFT  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOOT_RIGHT = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERTICAL    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRUSS_RIGHT = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRUSS_LEFT  = 4'd7;

  // reset values
  localparam logic [15:0] RST_GAIN_P      = 16'd328;
  localparam logic [15:0] RST_GAIN_I      = 16'd0;
  localparam logic [15:0] RST_GAIN_D      = 16'd4915;
  localparam int          RST_SHOOT_LEFT  = 580;
  localparam int          RST_SHOOT_RIGHT = 340;
  localparam int          RST_VERTICAL    = 460;
  localparam int          RST_TRUSS_RIGHT = 360;
  localparam int          RST_TRUSS_LEFT  = 560;

  // Q1.15 thresholds: 0.95 and 0.1
  localparam logic signed [15:0] OVERRIDE_ON = 16'sd31130;
  localparam logic signed [15:0] DEAD_ZONE   = 16'sd3277;

  localparam int TRIM_W = 11;
  localparam logic signed [TRIM_W:0] TRIM_STEP  = 12'sd5;
  localparam logic signed [TRIM_W:0] TRIM_LIMIT = 12'sd1000;

  localparam int DRIVE_W     = 16;
  localparam int DRIVE_LIMIT = 32767;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
  } appc_gains_t;

endpackage : appc_pkg
`default_nettype wire

// ===== rtl/appc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// appc_front: input classification
// Decides manual or closed-loop mode, trim and target per tick, and tells the
// back end whether the PID state is cleared.
// ----------------------------------------------------------------------------
module appc_front
  import appc_pkg::*;
#(
  parameter int POSITION_BITS = APPC_POSITION_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [15:0]           in_arm_axis,
  input  wire  signed [15:0]           in_override_axis,
  input  wire  [POSITION_BITS-1:0]     in_position,
  input  wire                          in_trim_down_button,
  input  wire                          in_trim_up_button,
  input  wire                          in_left_shot_button,
  input  wire                          in_right_shot_button,
  input  wire                          in_vertical_button,
  input  wire                          in_truss_right_button,
  input  wire                          in_truss_left_button,
  input  wire  [POSITION_BITS-1:0]     shoot_left_pos,
  input  wire  [POSITION_BITS-1:0]     shoot_right_pos,
  input  wire  [POSITION_BITS-1:0]     vertical_pos,
  input  wire  [POSITION_BITS-1:0]     truss_right_pos,
  input  wire  [POSITION_BITS-1:0]     truss_left_pos,
  output logic                         q_push,
  input  wire                          q_ready,
  output logic [POSITION_BITS-1:0]     q_pos,
  output logic [POSITION_BITS-1:0]     q_target,
  output logic signed [DRIVE_W-1:0]    q_manual,
  output logic                         q_auto,
  output logic                         q_clear,
  output logic signed [TRIM_W-1:0]     q_trim
);

  localparam int TW = ((POSITION_BITS > TRIM_W) ? POSITION_BITS : TRIM_W) + 2;
  localparam logic signed [TW-1:0] POS_MAX_S = TW'((1 << POSITION_BITS) - 1);

  logic                       auto_r, auto_nxt;
  logic                       hold_r, hold_nxt;
  logic                       down_r, down_nxt;
  logic                       up_r, up_nxt;
  logic [POSITION_BITS-1:0]   target_r, target_nxt;
  logic signed [TRIM_W-1:0]   trim_r, trim_nxt;

  logic                       active;
  logic                       clear;
  logic signed [DRIVE_W-1:0]  manual;
  logic signed [DRIVE_W:0]    half_w;
  logic signed [TRIM_W:0]     t;
  logic signed [TW-1:0]       left_w, right_w;

  function automatic logic [POSITION_BITS-1:0] clamp_pos(input logic signed [TW-1:0] v);
    logic [POSITION_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > POS_MAX_S) begin
      r = POS_MAX_S[POSITION_BITS-1:0];
    end else begin
      r = v[POSITION_BITS-1:0];
    end
    return r;
  endfunction

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    active = (in_arm_axis >= DEAD_ZONE) || (in_arm_axis <= -DEAD_ZONE);
    // divide by two, truncating toward zero
    half_w = ((DRIVE_W+1)'(in_arm_axis) + $signed({16'b0, in_arm_axis[15]})) >>> 1;

    auto_nxt   = auto_r;
    hold_nxt   = hold_r;
    target_nxt = target_r;
    clear      = 1'b0;
    manual     = '0;

    if (in_override_axis >= OVERRIDE_ON) begin
      if (active) begin
        manual   = in_arm_axis;
        auto_nxt = 1'b0;
      end
    end else if (active) begin
      manual   = half_w[DRIVE_W-1:0];
      hold_nxt = 1'b0;
      clear    = 1'b1;
      auto_nxt = 1'b0;
    end else if (!hold_r) begin
      target_nxt = in_position;
      hold_nxt   = 1'b1;
      auto_nxt   = 1'b1;
    end

    // trim steps on button release
    t        = (TRIM_W+1)'(trim_r);
    down_nxt = down_r;
    up_nxt   = up_r;
    if (in_trim_down_button) begin
      down_nxt = 1'b1;
    end else if (down_r) begin
      t = t - TRIM_STEP;
      if (t < -TRIM_LIMIT) t = -TRIM_LIMIT;
      down_nxt = 1'b0;
    end
    if (in_trim_up_button) begin
      up_nxt = 1'b1;
    end else if (up_r) begin
      t = t + TRIM_STEP;
      if (t > TRIM_LIMIT) t = TRIM_LIMIT;
      up_nxt = 1'b0;
    end
    trim_nxt = t[TRIM_W-1:0];

    left_w  = TW'($signed({1'b0, shoot_left_pos})) - TW'(trim_nxt);
    right_w = TW'($signed({1'b0, shoot_right_pos})) + TW'(trim_nxt);

    // later presets take priority
    if (in_left_shot_button)   target_nxt = clamp_pos(left_w);
    if (in_right_shot_button)  target_nxt = clamp_pos(right_w);
    if (in_vertical_button)    target_nxt = vertical_pos;
    if (in_truss_right_button) target_nxt = truss_right_pos;
    if (in_truss_left_button)  target_nxt = truss_left_pos;
    if (in_left_shot_button || in_right_shot_button || in_vertical_button ||
        in_truss_right_button || in_truss_left_button) begin
      clear    = 1'b1;
      auto_nxt = 1'b1;
    end
  end

  assign q_pos    = in_position;
  assign q_target = target_nxt;
  assign q_manual = manual;
  assign q_auto   = auto_nxt;
  assign q_clear  = clear;
  assign q_trim   = trim_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r   <= 1'b0;
      hold_r   <= 1'b0;
      down_r   <= 1'b0;
      up_r     <= 1'b0;
      target_r <= '0;
      trim_r   <= '0;
    end else if (q_push) begin
      auto_r   <= auto_nxt;
      hold_r   <= hold_nxt;
      down_r   <= down_nxt;
      up_r     <= up_nxt;
      target_r <= target_nxt;
      trim_r   <= trim_nxt;
    end
  end

endmodule : appc_front
`default_nettype wire

// ===== rtl/appc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// appc_queue: two-entry queue
// Decouples the classifier from the PID pipeline.
// ----------------------------------------------------------------------------
module appc_queue
  import appc_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  output logic              push_ready,
  input  wire  [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  wire               pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [DATA_W-1:0] mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule : appc_queue
`default_nettype wire

// ===== rtl/appc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// appc_back: PID pipeline
// Stage A updates error sum and last error, stage B forms the three products,
// the output stage adds, saturates and selects manual or closed-loop drive.
// ----------------------------------------------------------------------------
module appc_back
  import appc_pkg::*;
#(
  parameter int POSITION_BITS = APPC_POSITION_BITS,
  parameter int SUM_BITS      = APPC_SUM_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  appc_gains_t                  gains,
  input  wire                          q_valid,
  output logic                         q_ready,
  input  wire  [POSITION_BITS-1:0]     q_pos,
  input  wire  [POSITION_BITS-1:0]     q_target,
  input  wire  signed [DRIVE_W-1:0]    q_manual,
  input  wire                          q_auto,
  input  wire                          q_clear,
  input  wire  signed [TRIM_W-1:0]     q_trim,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [DRIVE_W-1:0]    out_drive,
  output logic                         out_closed_loop,
  output logic [POSITION_BITS-1:0]     out_target_now,
  output logic signed [TRIM_W-1:0]     out_correction_now
);

  localparam int EW  = POSITION_BITS + 1;
  localparam int DW  = POSITION_BITS + 2;
  localparam int SW  = SUM_BITS + 1;
  localparam int PEW = 17 + EW;
  localparam int PIW = 17 + SUM_BITS;
  localparam int PDW = 17 + DW;
  localparam int AW  = PIW + 2;
  localparam logic signed [AW-1:0] DMAX = AW'(DRIVE_LIMIT);
  localparam logic signed [AW-1:0] DMIN = -DMAX;

  logic                          en, pop;

  logic signed [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic signed [EW-1:0]          last_r, last_nxt;

  logic signed [EW-1:0]          e, base_last;
  logic signed [DW-1:0]          de;
  logic signed [SUM_BITS-1:0]    base_sum, sat_sum;
  logic signed [SW-1:0]          sum_w;

  // stage A
  logic                          a_v_r;
  logic signed [EW-1:0]          a_e_r;
  logic signed [DW-1:0]          a_de_r;
  logic signed [SUM_BITS-1:0]    a_sum_r;
  logic                          a_auto_r;
  logic signed [DRIVE_W-1:0]     a_manual_r;
  logic [POSITION_BITS-1:0]      a_target_r;
  logic signed [TRIM_W-1:0]      a_trim_r;

  // stage B
  logic                          b_v_r;
  logic signed [PEW-1:0]         b_pe_r;
  logic signed [PIW-1:0]         b_pi_r;
  logic signed [PDW-1:0]         b_pd_r;
  logic                          b_auto_r;
  logic signed [DRIVE_W-1:0]     b_manual_r;
  logic [POSITION_BITS-1:0]      b_target_r;
  logic signed [TRIM_W-1:0]      b_trim_r;

  // output stage
  logic                          o_v_r;
  logic signed [DRIVE_W-1:0]     o_drive_r;
  logic                          o_auto_r;
  logic [POSITION_BITS-1:0]      o_target_r;
  logic signed [TRIM_W-1:0]      o_trim_r;

  logic signed [AW-1:0]          acc;
  logic signed [DRIVE_W-1:0]     drive_sel;

  // whole pipeline advances when the output register is free or drains
  assign en      = !o_v_r || out_ready;
  assign q_ready = en;
  assign pop     = q_valid && en;

  always_comb begin
    e         = EW'($signed({1'b0, q_pos})) - EW'($signed({1'b0, q_target}));
    base_last = q_clear ? '0 : last_r;
    base_sum  = q_clear ? '0 : sum_r;
    de        = DW'(e) - DW'(base_last);
    sum_w     = SW'(base_sum) + SW'(e);
    if (sum_w[SW-1] != sum_w[SW-2]) begin
      sat_sum = sum_w[SW-1] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sat_sum = sum_w[SUM_BITS-1:0];
    end
    if (q_auto) begin
      sum_nxt  = sat_sum;
      last_nxt = e;
    end else begin
      sum_nxt  = base_sum;
      last_nxt = base_last;
    end
  end

  always_comb begin
    acc = AW'(b_pe_r) + AW'(b_pi_r) + AW'(b_pd_r);
    if (!b_auto_r) begin
      drive_sel = b_manual_r;
    end else if (acc > DMAX) begin
      drive_sel = DMAX[DRIVE_W-1:0];
    end else if (acc < DMIN) begin
      drive_sel = DMIN[DRIVE_W-1:0];
    end else begin
      drive_sel = acc[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      last_r <= '0;
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      if (pop) begin
        sum_r  <= sum_nxt;
        last_r <= last_nxt;
      end
      a_v_r <= pop;
      b_v_r <= a_v_r;
      o_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_e_r      <= e;
      a_de_r     <= de;
      a_sum_r    <= sat_sum;
      a_auto_r   <= q_auto;
      a_manual_r <= q_manual;
      a_target_r <= q_target;
      a_trim_r   <= q_trim;

      b_pe_r     <= PEW'($signed({1'b0, gains.kp})) * PEW'(a_e_r);
      b_pi_r     <= PIW'($signed({1'b0, gains.ki})) * PIW'(a_sum_r);
      b_pd_r     <= PDW'($signed({1'b0, gains.kd})) * PDW'(a_de_r);
      b_auto_r   <= a_auto_r;
      b_manual_r <= a_manual_r;
      b_target_r <= a_target_r;
      b_trim_r   <= a_trim_r;

      o_drive_r  <= drive_sel;
      o_auto_r   <= b_auto_r;
      o_target_r <= b_target_r;
      o_trim_r   <= b_trim_r;
    end
  end

  assign out_valid          = o_v_r;
  assign out_drive          = o_drive_r;
  assign out_closed_loop    = o_auto_r;
  assign out_target_now     = o_target_r;
  assign out_correction_now = o_trim_r;

  a_clear_pid: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_clear && !q_auto |=> (sum_r == '0) && (last_r == '0))
    else $error("PID state not cleared on manual transaction");

  a_hold_pid: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !q_clear && !q_auto |=> $stable(sum_r) && $stable(last_r))
    else $error("PID state changed without closed loop");

  a_drive_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_closed_loop |-> out_drive != {1'b1, {(DRIVE_W-1){1'b0}}})
    else $error("closed-loop drive outside clamp");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(b_v_r) && $stable(a_v_r))
    else $error("pipeline moved during output stall");

endmodule : appc_back
`default_nettype wire

// ===== rtl/arm_position_pid_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted transaction passes the queue, stage A, stage B and the
// output register. Throughput: one transaction per cycle while out_ready is
// high; the front-end mode, target and trim update and the PID error-sum
// update in stage A are the loops. A stalled output backs up a 2-entry queue,
// then in_ready drops. Reset (rst_n low, synchronous) clears mode, trim,
// target and PID state and loads the default gains and presets.
// ----------------------------------------------------------------------------
// arm_position_pid_controller: arm position controller top level
// Configuration registers, classifier front end, queue and PID back end.
// ----------------------------------------------------------------------------
module arm_position_pid_controller
  import appc_pkg::*;
#(
  parameter int POSITION_BITS = APPC_POSITION_BITS,
  parameter int SUM_BITS      = APPC_SUM_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [CFG_INDEX_W-1:0]       cfg_index,
  input  wire  [CFG_DATA_W-1:0]        cfg_wdata,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [15:0]           in_arm_axis,
  input  wire  signed [15:0]           in_override_axis,
  input  wire  [POSITION_BITS-1:0]     in_position,
  input  wire                          in_trim_down_button,
  input  wire                          in_trim_up_button,
  input  wire                          in_left_shot_button,
  input  wire                          in_right_shot_button,
  input  wire                          in_vertical_button,
  input  wire                          in_truss_right_button,
  input  wire                          in_truss_left_button,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [DRIVE_W-1:0]    out_drive,
  output logic                         out_closed_loop,
  output logic [POSITION_BITS-1:0]     out_target_now,
  output logic signed [TRIM_W-1:0]     out_correction_now
);

  localparam int QW = 2 * POSITION_BITS + DRIVE_W + 2 + TRIM_W;

  appc_gains_t               gains_r;
  logic [POSITION_BITS-1:0]  shoot_left_r, shoot_right_r, vertical_r;
  logic [POSITION_BITS-1:0]  truss_right_r, truss_left_r;

  logic                      f_push, f_ready;
  logic [POSITION_BITS-1:0]  f_pos, f_target;
  logic signed [DRIVE_W-1:0] f_manual;
  logic                      f_auto, f_clear;
  logic signed [TRIM_W-1:0]  f_trim;

  logic [QW-1:0]             qin, qout;
  logic                      b_valid, b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.kp    <= RST_GAIN_P;
      gains_r.ki    <= RST_GAIN_I;
      gains_r.kd    <= RST_GAIN_D;
      shoot_left_r  <= POSITION_BITS'(RST_SHOOT_LEFT);
      shoot_right_r <= POSITION_BITS'(RST_SHOOT_RIGHT);
      vertical_r    <= POSITION_BITS'(RST_VERTICAL);
      truss_right_r <= POSITION_BITS'(RST_TRUSS_RIGHT);
      truss_left_r  <= POSITION_BITS'(RST_TRUSS_LEFT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P:      gains_r.kp    <= cfg_wdata;
        CFG_GAIN_I:      gains_r.ki    <= cfg_wdata;
        CFG_GAIN_D:      gains_r.kd    <= cfg_wdata;
        CFG_SHOOT_LEFT:  shoot_left_r  <= cfg_wdata[POSITION_BITS-1:0];
        CFG_SHOOT_RIGHT: shoot_right_r <= cfg_wdata[POSITION_BITS-1:0];
        CFG_VERTICAL:    vertical_r    <= cfg_wdata[POSITION_BITS-1:0];
        CFG_TRUSS_RIGHT: truss_right_r <= cfg_wdata[POSITION_BITS-1:0];
        CFG_TRUSS_LEFT:  truss_left_r  <= cfg_wdata[POSITION_BITS-1:0];
        default: ;
      endcase
    end
  end

  appc_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_arm_axis           (in_arm_axis),
    .in_override_axis      (in_override_axis),
    .in_position           (in_position),
    .in_trim_down_button   (in_trim_down_button),
    .in_trim_up_button     (in_trim_up_button),
    .in_left_shot_button   (in_left_shot_button),
    .in_right_shot_button  (in_right_shot_button),
    .in_vertical_button    (in_vertical_button),
    .in_truss_right_button (in_truss_right_button),
    .in_truss_left_button  (in_truss_left_button),
    .shoot_left_pos        (shoot_left_r),
    .shoot_right_pos       (shoot_right_r),
    .vertical_pos          (vertical_r),
    .truss_right_pos       (truss_right_r),
    .truss_left_pos        (truss_left_r),
    .q_push                (f_push),
    .q_ready               (f_ready),
    .q_pos                 (f_pos),
    .q_target              (f_target),
    .q_manual              (f_manual),
    .q_auto                (f_auto),
    .q_clear               (f_clear),
    .q_trim                (f_trim)
  );

  assign qin = {f_pos, f_target, f_manual, f_auto, f_clear, f_trim};

  appc_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_ready (f_ready),
    .push_data  (qin),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (qout)
  );

  appc_back #(
    .POSITION_BITS (POSITION_BITS),
    .SUM_BITS      (SUM_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .gains              (gains_r),
    .q_valid            (b_valid),
    .q_ready            (b_ready),
    .q_pos              (qout[QW-1 -: POSITION_BITS]),
    .q_target           (qout[QW-POSITION_BITS-1 -: POSITION_BITS]),
    .q_manual           ($signed(qout[TRIM_W+2 +: DRIVE_W])),
    .q_auto             (qout[TRIM_W+1]),
    .q_clear            (qout[TRIM_W]),
    .q_trim             ($signed(qout[TRIM_W-1:0])),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_drive          (out_drive),
    .out_closed_loop    (out_closed_loop),
    .out_target_now     (out_target_now),
    .out_correction_now (out_correction_now)
  );

endmodule : arm_position_pid_controller
`default_nettype wire
